[rtl/ccpg_pkg.sv]
`default_nettype none

package ccpg_pkg;

    // Pattern lengths and index widths
    localparam int unsigned CRANK_LEN = 72;
    localparam int unsigned CAM_LEN   = 144;
    localparam int unsigned CRANK_IW  = 7;
    localparam int unsigned CAM_IW    = 8;

    // Field widths
    localparam int unsigned ADC_W  = 10;
    localparam int unsigned RPM_W  = 13;
    localparam int unsigned TOP_W  = 16;
    localparam int unsigned CNT_W  = 16;

    // Shared divider sizing: widest dividend is (volt - 1000) * 5400 < 2^25,
    // widest divisor is 72 * 100 = 7200 < 2^13.
    localparam int unsigned DIV_NW    = 25;
    localparam int unsigned DIV_DW    = 13;
    localparam int unsigned DIV_CNT_W = 5;

    // Speed mapping constants
    localparam logic [DIV_NW-1:0] VOLT_SPAN  = DIV_NW'(4000);
    localparam logic [DIV_DW-1:0] ADC_FULL   = DIV_DW'(1023);
    localparam logic [DIV_NW-1:0] RPM_SPAN   = DIV_NW'(5400);
    localparam logic [DIV_DW-1:0] VOLT_DIV   = DIV_DW'(4000);
    localparam logic [RPM_W-1:0]  RPM_MIN    = RPM_W'(600);
    localparam logic [DIV_DW-1:0] RPM_PER_RS = DIV_DW'(60);
    localparam logic [DIV_NW-1:0] TIMER_HZ   = DIV_NW'(250000);
    localparam logic [DIV_DW-1:0] STEPS_REV  = DIV_DW'(72);
    localparam logic [TOP_W-1:0]  TOP_RESET  = TOP_W'(249);

    // Speed computation phases
    localparam logic [1:0] PH_VOLT = 2'd0;
    localparam logic [1:0] PH_RPM  = 2'd1;
    localparam logic [1:0] PH_REVS = 2'd2;
    localparam logic [1:0] PH_TOP  = 2'd3;

    // Crank wheel: a tooth on every even half-step, except the gaps at 0, 36 and 70
    function automatic logic crank_pattern(input logic [CRANK_IW-1:0] idx);
        logic tooth;
        tooth = ~idx[0];
        if (idx == CRANK_IW'(0) || idx == CRANK_IW'(36) || idx == CRANK_IW'(70))
        begin
            tooth = 1'b0;
        end
        return tooth;
    endfunction

    // Cam wheel: high except over the listed low windows
    function automatic logic cam_pattern(input logic [CAM_IW-1:0] idx);
        logic level;
        level = 1'b1;
        if (idx inside {[8'd22:8'd28], [8'd32:8'd35], [8'd58:8'd64],
                        [8'd94:8'd100], [8'd130:8'd136], [8'd141:8'd143]})
        begin
            level = 1'b0;
        end
        return level;
    endfunction

endpackage

`default_nettype wire

[rtl/crank_cam_pattern_generator.sv]
// Timer tick item: its result is registered and shown the next cycle;
// ticks sustain one item per cycle while the output is taken and no speed sample is in progress.
// Speed sample item: four divisions in turn on one shared 25-step divider, then the result is
// shown once the output slot is free; no input is taken meanwhile.
// Reset (rst_n, asynchronous, active low): count 0, top 249, indexes and levels 0, rpm 0.
`default_nettype none

module crank_cam_pattern_generator
    import ccpg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [9:0] adc_sample
    input  wire logic        s_axis_tuser,  // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // [0] crank_level, [1] cam_level,
                                            // [14:2] engine_rpm, [30:15] step_top
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOP_W-1:0]    top_reg, top_next;
    logic [CRANK_IW-1:0] crank_idx_reg, crank_idx_next;
    logic [CAM_IW-1:0]   cam_idx_reg, cam_idx_next;
    logic                crank_bit_reg, crank_bit_next;
    logic                cam_bit_reg, cam_bit_next;
    logic [RPM_W-1:0]    rpm_reg, rpm_next;
    logic [RPM_W-1:0]    rpm_calc_reg, rpm_calc_next;
    logic [TOP_W-1:0]    top_calc_reg, top_calc_next;

    logic                in_fire, out_fire, slot_free;
    logic                div_start, div_done;
    logic [DIV_NW-1:0]   div_dividend, div_quot;
    logic [DIV_DW-1:0]   div_divisor;

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && slot_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;

    ccpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Tick handling and speed sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        crank_idx_next = crank_idx_reg;
        cam_idx_next   = cam_idx_reg;
        crank_bit_next = crank_bit_reg;
        cam_bit_next   = cam_bit_reg;
        rpm_next       = rpm_reg;
        rpm_calc_next  = rpm_calc_reg;
        top_calc_next  = top_calc_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser)
                    begin
                        // volt offset = adc * 4000 / 1023
                        div_start    = 1'b1;
                        div_dividend = DIV_NW'(s_axis_tdata[ADC_W-1:0]) * VOLT_SPAN;
                        div_divisor  = ADC_FULL;
                        phase_next   = PH_VOLT;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (count_reg == top_reg)
                        begin
                            count_next     = '0;
                            crank_bit_next = crank_pattern(crank_idx_reg);
                            cam_bit_next   = cam_pattern(cam_idx_reg);
                            crank_idx_next = (crank_idx_reg == CRANK_IW'(CRANK_LEN - 1)) ?
                                             '0 : crank_idx_reg + 1'b1;
                            cam_idx_next   = (cam_idx_reg == CAM_IW'(CAM_LEN - 1)) ?
                                             '0 : cam_idx_reg + 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_VOLT:
                        begin
                            // rpm offset = volt offset * 5400 / 4000
                            div_start    = 1'b1;
                            div_dividend = DIV_NW'(div_quot[11:0]) * RPM_SPAN;
                            div_divisor  = VOLT_DIV;
                            phase_next   = PH_RPM;
                        end
                        PH_RPM:
                        begin
                            // revs = rpm / 60
                            rpm_calc_next = RPM_MIN + div_quot[RPM_W-1:0];
                            div_start     = 1'b1;
                            div_dividend  = DIV_NW'(rpm_calc_next);
                            div_divisor   = RPM_PER_RS;
                            phase_next    = PH_REVS;
                        end
                        PH_REVS:
                        begin
                            // top = 250000 / (72 * revs) - 1
                            div_start    = 1'b1;
                            div_dividend = TIMER_HZ;
                            div_divisor  = DIV_DW'(div_quot[6:0]) * STEPS_REV;
                            phase_next   = PH_TOP;
                        end
                        PH_TOP:
                        begin
                            top_calc_next = div_quot[TOP_W-1:0] - 1'b1;
                            state_next    = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                // commit new speed once the output slot is free
                if (slot_free)
                begin
                    rpm_next       = rpm_calc_reg;
                    top_next       = top_calc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_VOLT;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            top_reg       <= TOP_RESET;
            crank_idx_reg <= '0;
            cam_idx_reg   <= '0;
            crank_bit_reg <= 1'b0;
            cam_bit_reg   <= 1'b0;
            rpm_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            crank_idx_reg <= crank_idx_next;
            cam_idx_reg   <= cam_idx_next;
            crank_bit_reg <= crank_bit_next;
            cam_bit_reg   <= cam_bit_next;
            rpm_reg       <= rpm_next;
        end
    end

    // Scratch results of the speed computation
    always_ff @(posedge clk)
    begin
        rpm_calc_reg <= rpm_calc_next;
        top_calc_reg <= top_calc_next;
    end

    // Result item comes straight from the state registers
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, top_reg, rpm_reg, cam_bit_reg, crank_bit_reg};

    // Checks
    a_speed_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_axis_tuser |=> state_reg == ST_DIV && !m_axis_tvalid || state_reg == ST_DIV)
        else $error("speed sample did not start the divider");

    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !s_axis_tuser |=> m_axis_tvalid)
        else $error("tick item produced no result");

    a_crank_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        crank_idx_reg < CRANK_IW'(CRANK_LEN) && cam_idx_reg < CAM_IW'(CAM_LEN))
        else $error("pattern index out of range");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> !div_start || div_done)
        else $error("divider restarted while still running");

endmodule

`default_nettype wire

[rtl/ccpg_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle
module ccpg_div
    import ccpg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] dividend,
    input  wire logic [DIV_DW-1:0] divisor,
    output logic                   done,
    output logic [DIV_NW-1:0]      quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NW-1:0]    acc_reg, acc_next;
    logic [DIV_DW-1:0]    rem_reg, rem_next;
    logic [DIV_DW-1:0]    dsr_reg, dsr_next;
    logic [DIV_DW:0]      trial;
    logic                 fits;

    // One trial subtraction
    assign trial = {rem_reg, acc_reg[DIV_NW-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[DIV_NW-2:0], fits};
            rem_next = fits ? DIV_DW'(trial - {1'b0, dsr_reg}) : trial[DIV_DW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

`default_nettype wire

[tb/crank_cam_pattern_generator_tb.sv]
`timescale 1ns / 1ps

module crank_cam_pattern_generator_tb;
    import ccpg_pkg::*;

    // Item kinds carried on s_axis_tuser
    typedef enum logic
    {
        OP_TICK  = 1'b0,
        OP_SPEED = 1'b1
    } item_op_t;

    // One sensor output item, in tdata order from the top bit down
    typedef struct packed
    {
        logic [TOP_W-1:0] step_top;
        logic [RPM_W-1:0] engine_rpm;
        logic             cam_level;
        logic             crank_level;
    } sensor_out_t;

    // Speed mapping constants
    localparam int unsigned TICK_HZ      = 250000;
    localparam int unsigned ADC_TOP      = 1023;
    localparam int unsigned MV_BASE      = 1000;
    localparam int unsigned MV_SPAN      = 4000;
    localparam int unsigned RPM_FLOOR    = 600;
    localparam int unsigned RPM_SPREAD   = 5400;
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned TEETH_STEPS  = 72;
    localparam int unsigned SETTLE_CYCLES = 20;

    // Crank wheel gap positions
    localparam int unsigned GAP_A = 0;
    localparam int unsigned GAP_B = 36;
    localparam int unsigned GAP_C = 70;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;   // [9:0] adc_sample
    logic              s_axis_tuser;   // [0] op
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;   // [0] crank_level, [1] cam_level,
                                       // [14:2] engine_rpm, [30:15] step_top

    // Sensor state mirror
    logic [CNT_W-1:0]    tick_cnt;
    logic [TOP_W-1:0]    top_val;
    logic [CRANK_IW-1:0] crank_pos;
    logic [CAM_IW-1:0]   cam_pos;
    logic                crank_lvl;
    logic                cam_lvl;
    logic [RPM_W-1:0]    rpm_val;
    logic                crank_wheel [CRANK_LEN];
    logic                cam_wheel [CAM_LEN];

    sensor_out_t expected_outputs [$];

    // Traffic shaping
    bit          tx_idle_en;
    bit          rx_stall_en;
    int unsigned burst_left;
    bit          rx_ready_phase;
    int unsigned rx_run_left;

    // Run statistics
    int unsigned items_sent;
    int unsigned speed_items;
    int unsigned pattern_steps;
    int unsigned overrun_ticks;
    int unsigned results_seen;
    int unsigned errors;

    crank_cam_pattern_generator uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Wheel tables: crank teeth on even steps minus the gaps, cam high outside its windows
    function automatic void build_wheels();
        int unsigned win_lo [6] = '{22, 32, 58, 94, 130, 141};
        int unsigned win_hi [6] = '{28, 35, 64, 100, 136, 143};
        for (int unsigned i = 0; i < CRANK_LEN; i++)
        begin
            crank_wheel[i] = (i % 2 == 0) && (i != GAP_A) && (i != GAP_B) && (i != GAP_C);
        end
        for (int unsigned i = 0; i < CAM_LEN; i++)
        begin
            cam_wheel[i] = 1'b1;
        end
        for (int w = 0; w < 6; w++)
        begin
            for (int unsigned i = win_lo[w]; i <= win_hi[w]; i++)
            begin
                cam_wheel[i] = 1'b0;
            end
        end
    endfunction

    function automatic void reset_sensor_state();
        tick_cnt  = '0;
        top_val   = TOP_RESET;
        crank_pos = '0;
        cam_pos   = '0;
        crank_lvl = 1'b0;
        cam_lvl   = 1'b0;
        rpm_val   = '0;
    endfunction

    // Advance the mirror by one item and return the sensor outputs after it
    function automatic sensor_out_t sensor_response(input item_op_t op,
                                                    input logic [ADC_W-1:0] adc);
        int unsigned mv;
        int unsigned rpm;
        int unsigned revs;
        sensor_out_t r;
        if (op == OP_SPEED)
        begin
            mv   = MV_BASE + (32'(adc) * MV_SPAN) / ADC_TOP;
            rpm  = RPM_FLOOR + ((mv - MV_BASE) * RPM_SPREAD) / MV_SPAN;
            revs = rpm / SEC_PER_MIN;
            rpm_val = RPM_W'(rpm);
            top_val = TOP_W'(TICK_HZ / (TEETH_STEPS * revs) - 1);
            speed_items++;
        end
        else if (tick_cnt == top_val)
        begin
            tick_cnt  = '0;
            crank_lvl = crank_wheel[crank_pos];
            cam_lvl   = cam_wheel[cam_pos];
            crank_pos = (crank_pos == CRANK_LEN - 1) ? '0 : crank_pos + 1'b1;
            cam_pos   = (cam_pos == CAM_LEN - 1) ? '0 : cam_pos + 1'b1;
            pattern_steps++;
        end
        else
        begin
            // counter above a lowered top keeps climbing without a step
            if (tick_cnt > top_val)
            begin
                overrun_ticks++;
            end
            tick_cnt = tick_cnt + 1'b1;
        end
        r.crank_level = crank_lvl;
        r.cam_level   = cam_lvl;
        r.engine_rpm  = rpm_val;
        r.step_top    = top_val;
        return r;
    endfunction

    // Send one item, with a random gap between bursts while idling is enabled
    task automatic send_item(input item_op_t op, input logic [ADC_W-1:0] adc);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = tx_idle_en ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, adc};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        expected_outputs.push_back(sensor_response(op, adc));
        items_sent++;
        burst_left--;
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(OP_TICK, ADC_W'($urandom));
    endtask

    // Receiver stall pattern: long ready runs, short stalls
    always @(posedge clk)
    begin
        if (rx_run_left == 0)
        begin
            rx_ready_phase = !rx_ready_phase;
            rx_run_left = rx_ready_phase ? $urandom_range(1, 30) : $urandom_range(1, 5);
        end
        rx_run_left--;
        m_axis_tready <= rx_ready_phase || !rx_stall_en;
    end

    // Result checker
    always @(posedge clk)
    begin : check_result
        sensor_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_outputs.size() == 0)
            begin
                $error("unexpected output item 0x%08h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (m_axis_tdata[0] !== want.crank_level)
                begin
                    $error("crank_level: expected %0d, got %0d", want.crank_level,
                           m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[1] !== want.cam_level)
                begin
                    $error("cam_level: expected %0d, got %0d", want.cam_level,
                           m_axis_tdata[1]);
                    errors++;
                end
                if (m_axis_tdata[14:2] !== want.engine_rpm)
                begin
                    $error("engine_rpm: expected %0d, got %0d", want.engine_rpm,
                           m_axis_tdata[14:2]);
                    errors++;
                end
                if (m_axis_tdata[30:15] !== want.step_top)
                begin
                    $error("step_top: expected %0d, got %0d", want.step_top,
                           m_axis_tdata[30:15]);
                    errors++;
                end
            end
        end
    end

    // Reset outputs, speed extremes, alternating ADC bits, back-to-back samples
    task automatic test_directed_speeds();
        send_ticks(3);
        send_item(OP_SPEED, 10'd0);
        send_item(OP_TICK, 10'd0);
        send_item(OP_SPEED, 10'd1023);
        send_item(OP_TICK, 10'd1023);
        send_item(OP_SPEED, 10'd512);
        send_item(OP_SPEED, 10'h155);
        send_item(OP_SPEED, 10'h2AA);
        send_item(OP_TICK, 10'h3FF);
        send_item(OP_SPEED, 10'd1);
        send_item(OP_SPEED, 10'd1022);
        send_ticks(2);
    endtask

    // Mostly ticks with occasional speed samples; one chunk runs without idling or receiver stalls
    task automatic test_random_traffic();
        logic [ADC_W-1:0] adc;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            tx_idle_en  = (chunk != 2);
            rx_stall_en = (chunk != 2);
            repeat (110)
            begin
                case ($urandom_range(0, 3))
                    0:       adc = '0;
                    1:       adc = '1;
                    default: adc = ADC_W'($urandom);
                endcase
                if ($urandom_range(0, 15) == 0)
                begin
                    send_item(OP_SPEED, adc);
                end
                else
                begin
                    send_item(OP_TICK, adc);
                end
            end
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // Slow speed, let the count climb, then drop the top beneath it:
    // the counter keeps rising past the new top without stepping
    task automatic test_top_lowered_below_count();
        int unsigned target;
        target = $urandom_range(45, 90);
        send_item(OP_SPEED, 10'd0);
        while (tick_cnt < target)
        begin
            send_item(OP_TICK, ADC_W'($urandom));
        end
        send_item(OP_SPEED, 10'd1023);
        send_ticks(16);
    endtask

    task automatic finish_run();
        s_axis_tvalid <= 1'b0;
        while (expected_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d items (%0d speed samples) covering %0d pattern steps and %0d ticks",
                 items_sent, speed_items, pattern_steps, overrun_ticks);
        $display("above a lowered top; checked %0d output items, %0d mismatches.",
                 results_seen, errors);
        if (errors == 0)
        begin
            $display("** crank_cam_pattern_generator: PASSED **");
        end
        else
        begin
            $display("** crank_cam_pattern_generator: FAILED **");
        end
        $finish;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_TICK;
        m_axis_tready  = 1'b0;
        tx_idle_en     = 1'b1;
        rx_stall_en    = 1'b1;
        burst_left     = 0;
        rx_ready_phase = 1'b0;
        rx_run_left    = 0;
        items_sent     = 0;
        speed_items    = 0;
        pattern_steps  = 0;
        overrun_ticks  = 0;
        results_seen   = 0;
        errors         = 0;
        build_wheels();
        reset_sensor_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_speeds();
        test_random_traffic();
        test_top_lowered_below_count();
        finish_run();
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d output items outstanding", expected_outputs.size());
        $display("** crank_cam_pattern_generator: FAILED **");
        $finish;
    end

endmodule
